// File: design/sha256_pkg.sv
// Package: SHA-256 constants, rotate function, channel word types and controller/datapath command and status types.
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_BYTES = 64;
    localparam int FILL_W  = 6;
    localparam int LEN_W   = 64;
    localparam int SUM_W   = 13;
    localparam int IDX_W   = 3;
    localparam int ROUND_W = 6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] LEN_POS = 6'd56;

    localparam logic [WORD_W-1:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    // Input channel word: one message byte with its flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_byte_word;

    // Output channel word: one digest word with its index, sum and last flag.
    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [IDX_W-1:0]  word_index;
        logic [SUM_W-1:0]  digest_byte_sum;
        logic              last_word;
    } t_digest_word;

    // Commands from controller to datapath.
    typedef struct packed {
        logic take_byte;   // write input byte at fill, advance fill
        logic pad_byte;    // write pad (0x80 first, zeros after) at fill, advance fill
        logic put_len;     // write the 64-bit length into bytes 56..63
        logic load;        // load working words from hash, start round 0
        logic round;       // run one round
        logic fold;        // add working words into hash
        logic restart;     // hash to initial values, fill and length to zero
        logic shift_out;   // rotate hash words toward word 0
    } t_cmd;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              last_round;
    } t_status;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int s);
        rotr = (v >> s) | (v << (WORD_W - s));
    endfunction

endpackage

// File: design/sha256_if.sv
// Valid/ready channel interface carrying a generic payload.
`timescale 1ns / 1ps
interface sha256_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/sha256_dp.sv
// Datapath: block buffer, message schedule, round logic, hash words, length and output sum.
`timescale 1ns / 1ps
module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_byte,
    input  sha256_pkg::t_cmd    i_cmd,
    output sha256_pkg::t_status o_status,
    output logic [31:0]         o_word0,
    output logic [12:0]         o_sum_next
);
    import sha256_pkg::*;

    // Block held as sixteen big-endian words; bytes land in their lane.
    logic [WORD_W-1:0] r_buf [BLOCK_BYTES/4];
    logic [FILL_W-1:0] r_fill;
    logic              r_pad_started;
    logic [LEN_W-1:0]  r_bits;
    logic [WORD_W-1:0] r_w [16];
    logic [WORD_W-1:0] r_h [8];
    logic [WORD_W-1:0] r_v [8];
    logic [ROUND_W-1:0] r_t;
    logic [12:0]       r_sum;

    logic [WORD_W-1:0] s0, s1, w_new, w_cur, t1, t2, ep, ap;
    logic [7:0]        wbyte;

    assign wbyte = i_cmd.take_byte ? i_byte : (r_pad_started ? 8'h00 : PAD_BYTE);

    // Schedule: W[t] is always r_w[0]; new word appended at r_w[15].
    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        ap = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        ep = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        t1 = r_v[7] + ep + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_t] + w_cur;
        t2 = ap + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte || i_cmd.pad_byte)
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= wbyte;
        if (i_cmd.put_len) begin
            r_buf[14] <= r_bits[63:32];
            r_buf[15] <= r_bits[31:0];
        end
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++) r_h[i] <= H_INIT[i];
            r_fill <= '0;
            r_pad_started <= 1'b0;
            r_bits <= '0;
            r_t <= '0;
            r_sum <= '0;
        end else begin
            if (i_cmd.take_byte) begin
                r_fill <= r_fill + 1'b1;
                r_bits <= r_bits + LEN_W'(8);
            end
            if (i_cmd.pad_byte) begin
                r_fill <= r_fill + 1'b1;
                r_pad_started <= 1'b1;
            end
            if (i_cmd.load) r_t <= '0;
            else if (i_cmd.round) r_t <= r_t + 1'b1;
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_sum <= '0;
            end
            if (i_cmd.shift_out) begin
                for (int i = 0; i < 7; i++) r_h[i] <= r_h[i+1];
                r_h[7] <= r_h[0];
                r_sum <= o_sum_next;
            end
        end
    end

    assign o_sum_next = r_sum + 13'(r_h[0][31:24]) + 13'(r_h[0][23:16])
                      + 13'(r_h[0][15:8]) + 13'(r_h[0][7:0]);
    assign o_word0 = r_h[0];
    assign o_status.fill = r_fill;
    assign o_status.last_round = (r_t == ROUND_W'(63));
endmodule

// File: design/sha256_ctrl.sv
// Controller: sequences byte intake, padding, compression rounds and digest output.
`timescale 1ns / 1ps
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_present,
    input  logic                i_end,
    input  logic                i_out_ready,
    input  sha256_pkg::t_status i_status,
    output sha256_pkg::t_cmd    o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic [2:0]          o_idx
);
    import sha256_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ROUND = 7'b0000010,
        S_FOLD  = 7'b0000100,
        S_PAD   = 7'b0001000,
        S_LEN   = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_closing, n_closing;  // message end pending
    logic   r_final, n_final;      // compression in flight is the last one
    logic [2:0] r_idx, n_idx;
    logic   in_fire;

    assign in_fire = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_idx = r_idx;

    always_comb begin
        n_state = r_state; n_closing = r_closing; n_final = r_final;
        n_idx = r_idx;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    o_cmd.take_byte = i_present;
                    n_closing = i_end;
                    n_final = 1'b0;
                    if (i_present && i_status.fill == FILL_W'(63)) begin
                        n_state = S_LOAD;   // full block: compress first
                    end else if (i_end) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                // pad until fill reaches 56 (length block) or wraps (extra block)
                o_cmd.pad_byte = 1'b1;
                if (i_status.fill == FILL_W'(63)) n_state = S_LOAD;
                else if (i_status.fill == LEN_POS - 1'b1) n_state = S_LEN;
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                n_final = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.last_round) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_idx = '0;
                if (r_final) n_state = S_OUT;
                else if (r_closing) n_state = S_PAD;
                else n_state = S_IDLE;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd7) begin
                        o_cmd.shift_out = 1'b0;
                        o_cmd.restart = 1'b1;
                        n_closing = 1'b0;
                        n_final = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_closing <= 1'b0; r_final <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state; r_closing <= n_closing; r_final <= n_final;
            r_idx <= n_idx;
        end
    end
endmodule

// File: design/sha256_byte_stream_hasher.sv
// Top level: SHA-256 hasher over a byte stream with valid/ready word channels.
// A user should know: the block takes one word (one byte, with present and end
// flags) per cycle while a block fills; the 64th byte starts a compression
// (load, 64 rounds, fold) on the single shared round unit, during which input
// stalls. An end word pads one byte per cycle up to byte 56 (a second block when
// 56 or more bytes are held), writes the bit length, compresses, then offers the
// eight digest words, word 0 first, one per accepted output word, the last one
// flagged and carrying the sum of all 32 digest bytes. Input waits until the
// digest has been taken; the hash then restarts for the next message.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sha256_if.sink   i_in,
    sha256_if.source o_out
);
    import sha256_pkg::*;

    t_cmd       cmd;
    t_status    status;
    logic [31:0] word0;
    logic [12:0] sum_next;
    logic [2:0]  idx;
    logic        out_valid;

    // Control: sequence intake, padding, rounds and output.
    sha256_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_in.valid),
        .i_present  (i_in.payload.byte_present),
        .i_end      (i_in.payload.end_of_message),
        .i_out_ready(o_out.ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready),
        .o_out_valid(out_valid),
        .o_idx      (idx)
    );

    // Datapath: buffer, schedule, round unit, hash words.
    sha256_dp u_dp (
        .i_clk, .i_rst_n,
        .i_byte    (i_in.payload.data_byte),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_word0   (word0),
        .o_sum_next(sum_next)
    );

    assign o_out.valid = out_valid;
    assign o_out.payload.digest_word = word0;
    assign o_out.payload.word_index = idx;
    assign o_out.payload.last_word = (idx == 3'd7);
    assign o_out.payload.digest_byte_sum = (idx == 3'd7) ? sum_next : 13'd0;

    // Input is never taken while the digest is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("input ready during digest output");

    // After the last digest word is taken, input is open again.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.payload.last_word) |=> i_in.ready)
        else $error("block did not return to intake after digest");

    // Word index advances by one per taken digest word.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.payload.last_word) |=>
        (o_out.payload.word_index == $past(o_out.payload.word_index) + 3'd1))
        else $error("digest word index skipped");
endmodule
